### rtl/assert_macros.svh
// Assertion macros used by the checker file of the hash table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define HLTP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks a property at every rising clock edge, also while reset is asserted.
`define HLTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hltp_pkg.sv
// Package with the types, constants and codes of the linear probing hash table.
package hltp_pkg;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int SIZE_W   = 7;
	localparam int MAX_SIZE = 127;
	localparam int SUM_W    = 11;
	localparam int STEP_W   = $clog2(SUM_W + 1);

	localparam int SLOTS_DEF      = 64;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [SIZE_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic              done;
		logic [SIZE_W-1:0] rem;
	} mod_rsp_t;

endpackage

### rtl/hltp_ifs.sv
// Handshake interfaces for the command, result and configuration channels.
interface hltp_in_if;
	logic                      valid;
	logic                      ready;
	logic [hltp_pkg::CMD_W-1:0] cmd;
	logic [hltp_pkg::KEY_W-1:0] key;
	logic [hltp_pkg::VAL_W-1:0] value;

	modport source (output valid, cmd, key, value, input ready);
	modport sink (input valid, cmd, key, value, output ready);
endinterface

interface hltp_out_if;
	logic                         valid;
	logic                         ready;
	logic [hltp_pkg::STATUS_W-1:0] status;
	logic [hltp_pkg::VAL_W-1:0]    found_value;

	modport source (output valid, status, found_value, input ready);
	modport sink (input valid, status, found_value, output ready);
endinterface

interface hltp_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [hltp_pkg::SIZE_W-1:0] table_size;

	modport source (output valid, table_size, input ready);
	modport sink (input valid, table_size, output ready);
endinterface

### rtl/hltp_ram.sv
// Generic single-port RAM with a registered read.
module hltp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/hltp_mod.sv
// Bit-serial remainder unit that reduces the key byte sum modulo the table size.
module hltp_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  hltp_pkg::mod_req_t req,
	output hltp_pkg::mod_rsp_t rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [hltp_pkg::STEP_W-1:0]       cnt_q;
	logic [hltp_pkg::SUM_W-1:0]        dvd_q;
	logic [hltp_pkg::SIZE_W-1:0]       div_q;
	logic [hltp_pkg::SIZE_W-1:0]       rem_q;
	logic [hltp_pkg::SIZE_W:0]         trial;
	logic [hltp_pkg::SIZE_W:0]         trial_sub;
	logic [hltp_pkg::SIZE_W-1:0]       rem_next;

	always_comb begin
		trial     = {rem_q, dvd_q[hltp_pkg::SUM_W-1]};
		trial_sub = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_next = trial_sub[hltp_pkg::SIZE_W-1:0];
		end else begin
			rem_next = trial[hltp_pkg::SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= hltp_pkg::STEP_W'(hltp_pkg::SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == hltp_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

### rtl/hash_table_linear_probe_top.sv
// Top level of the open-addressed hash table with linear probing.
// Channels: req carries one transaction per command (cmd, key, value); rsp returns
// exactly one transaction per command (status, found_value); cfg writes table_size
// and is always ready, but it may only be written while no command is in flight.
// Commands are handled one at a time. After a command is accepted, the key byte sum
// is reduced modulo the table size by a bit-serial remainder unit, and the probe
// starts once the remainder unit is done.
// The probe then steps one slot per cycle: delete and find read the record RAM, with
// the compare in the cycle after the read, and insert checks only the valid flags.
// It stops at the first empty slot (insert) or the first valid matching key (delete,
// find), or once every slot in use has been probed. Command code 3 skips the hash
// and probe and goes straight to the finish state. The next command can be accepted
// in the cycle after the result is loaded into the output register.
// Reset clears every valid flag at once, so all slots are empty right after reset
// with no clearing pass, and sets table_size to 64.
// The result sits in an output register; a new command is accepted while it waits.
// If the receiver stalls, a finished command holds in its last state until the
// output register is free.
module hash_table_linear_probe_top #(
	parameter int SLOTS      = hltp_pkg::SLOTS_DEF,
	parameter int KEY_BYTES  = hltp_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = hltp_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hltp_cfg_if.sink    cfg,
	hltp_in_if.sink     req,
	hltp_out_if.source  rsp
);

	localparam int DEPTH = (SLOTS < hltp_pkg::MAX_SIZE) ? SLOTS : hltp_pkg::MAX_SIZE;
	localparam int IW    = $clog2(DEPTH);
	localparam int KW    = 8 * KEY_BYTES;
	localparam int VW    = (VALUE_BITS < hltp_pkg::VAL_W) ? VALUE_BITS : hltp_pkg::VAL_W;

	hltp_pkg::state_t state_q;
	hltp_pkg::state_t state_d;

	logic [hltp_pkg::SIZE_W-1:0]   table_size_q;
	logic [hltp_pkg::SIZE_W-1:0]   n_d;
	logic [hltp_pkg::SIZE_W-1:0]   n_q;
	logic [hltp_pkg::SUM_W-1:0]    sum_d;
	logic [hltp_pkg::CMD_W-1:0]    cmd_q;
	logic [KW-1:0]                 key_q;
	logic [VW-1:0]                 value_q;
	logic [IW-1:0]                 idx_q;
	logic [hltp_pkg::SIZE_W-1:0]   off_q;
	logic [hltp_pkg::SIZE_W-1:0]   off_inc;
	logic [hltp_pkg::SIZE_W-1:0]   idx_inc;
	logic [IW-1:0]                 idx_next;
	logic [DEPTH-1:0]              valid_q;

	logic                          rd_pend_s1;
	logic                          slot_valid_s1;
	logic [IW-1:0]                 idx_s1;

	logic [hltp_pkg::STATUS_W-1:0] res_status_q;
	logic [VW-1:0]                 res_fv_q;
	logic                          out_valid_q;
	logic [hltp_pkg::STATUS_W-1:0] out_status_q;
	logic [VW-1:0]                 out_fv_q;

	logic                          in_accept;
	logic                          is_insert;
	logic                          ins_free;
	logic                          ins_full;
	logic                          hit;
	logic                          miss;
	logic                          issue;
	logic                          advance;
	logic                          probe_done;
	logic                          load_out;
	logic                          ram_en;
	logic                          ram_we;
	logic [KW+VW-1:0]              ram_rdata;
	logic [KW-1:0]                 rd_key;
	logic [VW-1:0]                 rd_value;

	hltp_pkg::mod_req_t            mod_req;
	hltp_pkg::mod_rsp_t            mod_rsp;

	hltp_ram #(
		.WIDTH (KW + VW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (idx_q),
		.wdata ({key_q, value_q}),
		.rdata (ram_rdata)
	);

	hltp_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	assign rd_key   = ram_rdata[KW+VW-1:VW];
	assign rd_value = ram_rdata[VW-1:0];

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			sum_d = sum_d + hltp_pkg::SUM_W'(req.key[8*i +: 8]);
		end
	end

	always_comb begin
		if (table_size_q == '0) begin
			n_d = hltp_pkg::SIZE_W'(1);
		end else if (table_size_q > hltp_pkg::SIZE_W'(DEPTH)) begin
			n_d = hltp_pkg::SIZE_W'(DEPTH);
		end else begin
			n_d = table_size_q;
		end
	end

	always_comb begin
		off_inc  = off_q + 1'b1;
		idx_inc  = hltp_pkg::SIZE_W'(idx_q) + 1'b1;
		idx_next = (idx_inc == n_q) ? '0 : idx_inc[IW-1:0];
	end

	// Probe decisions and handshake outputs.
	always_comb begin
		in_accept  = (state_q == hltp_pkg::ST_IDLE) && req.valid;
		is_insert  = (cmd_q == hltp_pkg::CMD_INSERT);
		ins_free   = (state_q == hltp_pkg::ST_PROBE) && is_insert && !valid_q[idx_q];
		ins_full   = (state_q == hltp_pkg::ST_PROBE) && is_insert && valid_q[idx_q]
			&& (off_inc == n_q);
		hit        = (state_q == hltp_pkg::ST_PROBE) && !is_insert && rd_pend_s1
			&& slot_valid_s1 && (rd_key == key_q);
		miss       = (state_q == hltp_pkg::ST_PROBE) && !is_insert && !rd_pend_s1
			&& (off_q == n_q);
		issue      = (state_q == hltp_pkg::ST_PROBE) && !is_insert && !hit && (off_q != n_q);
		advance    = issue || ((state_q == hltp_pkg::ST_PROBE) && is_insert && !ins_free);
		probe_done = ins_free || ins_full || hit || miss;
		load_out   = (state_q == hltp_pkg::ST_FINISH) && (!out_valid_q || rsp.ready);
		ram_en     = issue || ins_free;
		ram_we     = ins_free;

		mod_req.start    = in_accept && (req.cmd != hltp_pkg::CMD_NONE);
		mod_req.dividend = sum_d;
		mod_req.divisor  = n_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hltp_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = (req.cmd == hltp_pkg::CMD_NONE) ? hltp_pkg::ST_FINISH
						: hltp_pkg::ST_HASH;
				end
			end
			hltp_pkg::ST_HASH: begin
				if (mod_rsp.done) begin
					state_d = hltp_pkg::ST_PROBE;
				end
			end
			hltp_pkg::ST_PROBE: begin
				if (probe_done) begin
					state_d = hltp_pkg::ST_FINISH;
				end
			end
			hltp_pkg::ST_FINISH: begin
				if (load_out) begin
					state_d = hltp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hltp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hltp_pkg::ST_IDLE;
			table_size_q <= hltp_pkg::SIZE_RESET;
			rd_pend_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				table_size_q <= cfg.table_size;
			end
			rd_pend_s1 <= issue;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ins_free) begin
			valid_q[idx_q] <= 1'b1;
		end else if (hit && (cmd_q == hltp_pkg::CMD_DELETE)) begin
			valid_q[idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q        <= req.cmd;
			key_q        <= req.key[KW-1:0];
			value_q      <= req.value[VW-1:0];
			n_q          <= n_d;
			res_status_q <= hltp_pkg::STAT_MISS;
			res_fv_q     <= '0;
		end
		if ((state_q == hltp_pkg::ST_HASH) && mod_rsp.done) begin
			idx_q <= mod_rsp.rem[IW-1:0];
			off_q <= '0;
		end else if (advance) begin
			idx_q <= idx_next;
			off_q <= off_inc;
		end
		idx_s1        <= idx_q;
		slot_valid_s1 <= valid_q[idx_q];
		if (ins_free) begin
			res_status_q <= hltp_pkg::STAT_DONE;
		end else if (ins_full) begin
			res_status_q <= hltp_pkg::STAT_FULL;
		end else if (hit) begin
			res_status_q <= hltp_pkg::STAT_DONE;
			if (cmd_q == hltp_pkg::CMD_FIND) begin
				res_fv_q <= rd_value;
			end
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_fv_q     <= res_fv_q;
		end
	end

	assign req.ready       = (state_q == hltp_pkg::ST_IDLE);
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_value = hltp_pkg::VAL_W'(out_fv_q);

endmodule

### rtl/hltp_checker.sv
// Port-level checker for the hash table and the bind that attaches it.
`include "assert_macros.svh"

module hltp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hltp_pkg::STATUS_W-1:0] status,
	input logic [hltp_pkg::VAL_W-1:0]    found_value
);

	// No result is offered while reset is asserted.
	`HLTP_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |-> !out_valid, "result valid during reset")

	// A result that is not taken stays unchanged.
	`HLTP_ASSERT(a_result_holds, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_value), "stalled result changed")

	// A result that is not done (miss or full) carries a zero value.
	`HLTP_ASSERT(a_value_only_on_hit, clk, arst_n, out_valid && (status != hltp_pkg::STAT_DONE) |-> (found_value == '0), "nonzero value without a hit")

	// Commands are handled one at a time.
	`HLTP_ASSERT(a_one_at_a_time, clk, arst_n, in_valid && in_ready |=> !in_ready, "command accepted while busy")

endmodule

bind hash_table_linear_probe_top hltp_checker u_hltp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.status      (rsp.status),
	.found_value (rsp.found_value)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the linear probing hash table, with a built-in table predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	class hash_table_scoreboard;
		typedef struct {
			logic [hltp_pkg::STATUS_W-1:0] status;
			logic [hltp_pkg::VAL_W-1:0]    found_value;
		} reply_t;

		logic [hltp_pkg::KEY_W-1:0]  slot_key [hltp_pkg::SLOTS_DEF];
		logic [hltp_pkg::VAL_W-1:0]  slot_value [hltp_pkg::SLOTS_DEF];
		bit                          slot_used [hltp_pkg::SLOTS_DEF];
		logic [hltp_pkg::SIZE_W-1:0] table_size;
		reply_t                      pending_replies [$];
		int                          failures;

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_key[i] = '0;
				slot_value[i] = '0;
			end
			table_size = hltp_pkg::SIZE_RESET;
			failures = 0;
		endfunction

		function void set_size(logic [hltp_pkg::SIZE_W-1:0] size);
			table_size = size;
		endfunction

		function int unsigned active_slots();
			if (table_size == 0) begin
				return 1;
			end
			if (table_size > hltp_pkg::SLOTS_DEF) begin
				return hltp_pkg::SLOTS_DEF;
			end
			return table_size;
		endfunction

		function int unsigned home_of(logic [hltp_pkg::KEY_W-1:0] key, int unsigned n);
			int unsigned sum;
			sum = 0;
			for (int b = 0; b < hltp_pkg::KEY_BYTES_DEF; b++) begin
				sum += key[8*b +: 8];
			end
			return sum % n;
		endfunction

		function int unsigned slot_of(logic [hltp_pkg::KEY_W-1:0] key, int unsigned n);
			int unsigned h;
			int unsigned s;
			h = home_of(key, n);
			for (int unsigned off = 0; off < n; off++) begin
				s = (h + off) % n;
				if (slot_used[s] && slot_key[s] == key) begin
					return s;
				end
			end
			return n;
		endfunction

		function void note_command(logic [hltp_pkg::CMD_W-1:0] cmd,
				logic [hltp_pkg::KEY_W-1:0] key, logic [hltp_pkg::VAL_W-1:0] value);
			int unsigned n;
			int unsigned h;
			int unsigned s;
			reply_t r;
			n = active_slots();
			r.status = hltp_pkg::STAT_MISS;
			r.found_value = '0;
			case (cmd)
				hltp_pkg::CMD_INSERT: begin
					r.status = hltp_pkg::STAT_FULL;
					h = home_of(key, n);
					for (int unsigned off = 0; off < n; off++) begin
						s = (h + off) % n;
						if (!slot_used[s]) begin
							slot_used[s] = 1'b1;
							slot_key[s] = key;
							slot_value[s] = value;
							r.status = hltp_pkg::STAT_DONE;
							break;
						end
					end
				end
				hltp_pkg::CMD_DELETE: begin
					s = slot_of(key, n);
					if (s < n) begin
						slot_used[s] = 1'b0;
						r.status = hltp_pkg::STAT_DONE;
					end
				end
				hltp_pkg::CMD_FIND: begin
					s = slot_of(key, n);
					if (s < n) begin
						r.status = hltp_pkg::STAT_DONE;
						r.found_value = slot_value[s];
					end
				end
				default: begin
				end
			endcase
			pending_replies = {pending_replies, r};
		endfunction

		function void flag(string what, logic [hltp_pkg::VAL_W-1:0] exp,
				logic [hltp_pkg::VAL_W-1:0] act);
			failures++;
			if (failures <= 10) begin
				$display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, exp, act);
			end
		endfunction

		function void check_result(logic [hltp_pkg::STATUS_W-1:0] status,
				logic [hltp_pkg::VAL_W-1:0] found_value);
			reply_t r;
			if (pending_replies.size() == 0) begin
				flag("unexpected result status", '1, status);
				return;
			end
			r = pending_replies.pop_front();
			if (status !== r.status) begin
				flag("status", r.status, status);
			end
			if (found_value !== r.found_value) begin
				flag("found_value", r.found_value, found_value);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet = 1'b0;
	bit   hold_req = 1'b0;

	hltp_cfg_if cfg_if();
	hltp_in_if  req_if();
	hltp_out_if rsp_if();

	hash_table_scoreboard sb;

	logic [hltp_pkg::KEY_W-1:0]  key_pool [72];
	logic [hltp_pkg::SIZE_W-1:0] phase_size [14] = '{7'd5, 7'd64, 7'd0, 7'd2, 7'd127, 7'd13,
		7'd1, 7'd65, 7'd40, 7'd7, 7'd64, 7'd3, 7'd100, 7'd24};

	hash_table_linear_probe_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #5 clk = ~clk;

	initial begin : watchdog
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [hltp_pkg::KEY_W-1:0] fresh_key();
		logic [hltp_pkg::KEY_W-1:0] k;
		int nb;
		k = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0) begin
			nb = $urandom_range(1, 7);
			k = k & (64'hFFFF_FFFF_FFFF_FFFF >> (64 - 8 * nb));
		end
		return k;
	endfunction

	task automatic issue_command(input logic [hltp_pkg::CMD_W-1:0] cmd,
			input logic [hltp_pkg::KEY_W-1:0] key, input logic [hltp_pkg::VAL_W-1:0] value);
		int gap;
		req_if.valid <= 1'b1;
		req_if.cmd <= cmd;
		req_if.key <= key;
		req_if.value <= value;
		forever begin
			@(posedge clk);
			if (req_if.ready) begin
				break;
			end
		end
		sb.note_command(cmd, key, value);
		@(negedge clk);
		gap = idle_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_replies();
		req_if.valid <= 1'b0;
		while (sb.pending_replies.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic set_table_size(input logic [hltp_pkg::SIZE_W-1:0] size);
		drain_replies();
		cfg_if.valid <= 1'b1;
		cfg_if.table_size <= size;
		forever begin
			@(posedge clk);
			if (cfg_if.ready) begin
				break;
			end
		end
		sb.set_size(size);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [hltp_pkg::SIZE_W-1:0] size, input int count,
			input bit squeeze);
		int pool_len;
		int r;
		logic [hltp_pkg::CMD_W-1:0] cmd;
		logic [hltp_pkg::KEY_W-1:0] key;
		set_table_size(size);
		pool_len = sb.active_slots() + 3;
		foreach (key_pool[i]) begin
			if ($urandom_range(0, 1) == 1) begin
				key_pool[i] = fresh_key();
			end
		end
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				cmd = hltp_pkg::CMD_INSERT;
			end else if (r < 65) begin
				cmd = hltp_pkg::CMD_DELETE;
			end else if (r < 95) begin
				cmd = hltp_pkg::CMD_FIND;
			end else begin
				cmd = hltp_pkg::CMD_NONE;
			end
			if ($urandom_range(0, 9) == 0) begin
				key = fresh_key();
			end else begin
				key = key_pool[$urandom_range(0, pool_len - 1)];
			end
			issue_command(cmd, key, $urandom);
			if (squeeze && i == 10) begin
				hold_req = 1'b1;
			end
		end
	endtask

	initial begin : rsp_sink
		int rx_wait;
		rx_wait = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rx_wait = 300;
			end
			if (rx_wait > 0) begin
				rsp_if.ready <= 1'b0;
				rx_wait--;
			end else begin
				rsp_if.ready <= 1'b1;
				rx_wait = idle_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			sb.check_result(rsp_if.status, rsp_if.found_value);
		end
	end

	initial begin : stimulus
		sb = new();
		arst_n = 1'b1;
		req_if.valid = 1'b0;
		req_if.cmd = hltp_pkg::CMD_INSERT;
		req_if.key = '0;
		req_if.value = '0;
		cfg_if.valid = 1'b0;
		cfg_if.table_size = hltp_pkg::SIZE_RESET;
		foreach (key_pool[i]) begin
			key_pool[i] = fresh_key();
		end
		@(negedge clk);
		arst_n <= 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue_command(hltp_pkg::CMD_FIND, 64'h0, 32'h0);
		issue_command(hltp_pkg::CMD_INSERT, 64'h0, 32'h0);
		issue_command(hltp_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		issue_command(hltp_pkg::CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		issue_command(hltp_pkg::CMD_INSERT, 64'h0, 32'h1234_5678);
		issue_command(hltp_pkg::CMD_FIND, 64'h0, 32'hFFFF_FFFF);
		issue_command(hltp_pkg::CMD_DELETE, 64'h0, 32'h0);
		issue_command(hltp_pkg::CMD_FIND, 64'h0, 32'h0);
		issue_command(hltp_pkg::CMD_DELETE, 64'hDEAD, 32'h0);
		issue_command(hltp_pkg::CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		issue_command(hltp_pkg::CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
		issue_command(hltp_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);

		set_table_size(7'd1);
		issue_command(hltp_pkg::CMD_INSERT, 64'h0102, 32'hCAFE_0001);
		issue_command(hltp_pkg::CMD_INSERT, 64'h0304, 32'hCAFE_0002);
		issue_command(hltp_pkg::CMD_FIND, 64'h0102, 32'h0);
		issue_command(hltp_pkg::CMD_DELETE, 64'h0102, 32'h0);
		issue_command(hltp_pkg::CMD_FIND, 64'h0102, 32'h0);

		set_table_size(7'd0);
		issue_command(hltp_pkg::CMD_INSERT, 64'hFF, 32'h0BAD_F00D);
		issue_command(hltp_pkg::CMD_FIND, 64'hFF, 32'h0);

		set_table_size(7'd127);
		issue_command(hltp_pkg::CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		issue_command(hltp_pkg::CMD_FIND, 64'hFF, 32'h0);

		for (int p = 0; p < 14; p++) begin
			quiet = (p == 3 || p == 10);
			run_phase(phase_size[p], 130, p == 1 || p == 8);
		end
		quiet = 1'b0;

		drain_replies();
		repeat (100) @(negedge clk);
		if (sb.failures == 0 && sb.pending_replies.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
